// ----- sv/ptpsb_pkg.sv -----
package ptpsb_pkg;

    // Fixed widths of the request and result fields
    localparam int PW   = 18;   // point coordinate
    localparam int RW   = 17;   // range register
    localparam int OW   = 18;   // reported range
    localparam int BNW  = 10;   // bin number field

    // CORDIC datapath widths: 4 guard bits, sign, and growth headroom
    localparam int XW   = 25;
    localparam int ZW   = 34;
    localparam int AT_W = 30;

    // Shared multiplier operand widths
    localparam int MAW  = 33;
    localparam int MBW  = 30;
    localparam int MPW  = MAW + MBW;

    localparam logic [MBW-1:0]    GAIN_INV_Q30 = 30'd652032874;
    localparam logic [MPW:0]      RANGE_BIAS   = 64'h0000_0002_0000_0000;
    localparam logic signed [ZW-1:0] HALF_TURN = 34'sh0_8000_0000;
    localparam logic signed [ZW:0]   U_OFFSET  = 35'sh0_8000_0000;

    localparam logic [OW-1:0] EMPTY_EXTRA = 18'd1024;
    localparam logic [OW-1:0] EMPTY_RESET = 18'd103424;
    localparam logic [OW-1:0] RANGE_SAT   = 18'h3FFFF;

    localparam logic [RW-1:0] MIN_RANGE_RST = 17'd10;
    localparam logic [RW-1:0] MAX_RANGE_RST = 17'd102400;

    // Configuration register indexes
    localparam logic REG_MIN_RANGE = 1'b0;
    localparam logic REG_MAX_RANGE = 1'b1;

    // atan(2^-i), full circle = 2^32
    localparam logic [AT_W-1:0] ATAN_TAB [32] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81,
        30'd41,        30'd20,        30'd10,        30'd5,
        30'd3,         30'd1,         30'd1,         30'd0
    };

    typedef struct packed {
        logic load;
        logic advance;
    } cordic_ctrl_t;

    typedef struct packed {
        logic we;
        logic re;
    } mem_ctrl_t;

endpackage

// ----- sv/ptpsb_cordic.sv -----
module ptpsb_cordic
    import ptpsb_pkg::*;
#(
    parameter int CORDIC_STEPS = 18
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cordic_ctrl_t          ctrl,
    input  logic signed [PW-1:0]  point_x,
    input  logic signed [PW-1:0]  point_y,
    output logic signed [XW-1:0]  x_out,
    output logic signed [ZW-1:0]  z_out,
    output logic                  last
);

    localparam int SCW = $clog2(CORDIC_STEPS);

    logic signed [XW-1:0] x_reg, x_next;
    logic signed [XW-1:0] y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic [SCW-1:0]       step_reg, step_next;

    logic signed [XW-1:0] x0, y0, dx, dy;
    logic signed [ZW-1:0] atan_s;
    logic                 y_pos;

    assign x0 = $signed({{(XW-PW-4){point_x[PW-1]}}, point_x, 4'b0000});
    assign y0 = $signed({{(XW-PW-4){point_y[PW-1]}}, point_y, 4'b0000});

    // Floor shifts of the old coordinates
    assign dx     = y_reg >>> step_reg;
    assign dy     = x_reg >>> step_reg;
    assign atan_s = $signed({{(ZW-AT_W){1'b0}}, ATAN_TAB[5'(step_reg)]});
    assign y_pos  = !y_reg[XW-1] && (|y_reg);

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        step_next = step_reg;
        if (ctrl.load)
        begin
            step_next = '0;
            if (point_x[PW-1])
            begin
                // Fold the left half plane onto the right one
                x_next = -x0;
                y_next = -y0;
                z_next = point_y[PW-1] ? -HALF_TURN : HALF_TURN;
            end
            else
            begin
                x_next = x0;
                y_next = y0;
                z_next = '0;
            end
        end
        else if (ctrl.advance)
        begin
            step_next = step_reg + 1'b1;
            if (y_pos)
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + atan_s;
            end
            else
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - atan_s;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign x_out = x_reg;
    assign z_out = z_reg;
    assign last  = (step_reg == SCW'(CORDIC_STEPS - 1));

endmodule

// ----- sv/ptpsb_bin_mem.sv -----
module ptpsb_bin_mem
    import ptpsb_pkg::*;
#(
    parameter int DEPTH = 640,
    parameter int AW    = 10
)
(
    input  logic          clk,
    input  mem_ctrl_t     ctrl,
    input  logic [AW-1:0] addr,
    input  logic [OW-1:0] wdata,
    output logic [OW-1:0] rdata
);

    logic [OW-1:0] mem [DEPTH];
    logic [OW-1:0] rdata_reg;

    // Read-first: a read and a clearing write may hit the same entry
    always_ff @(posedge clk)
    begin
        if (ctrl.re)
        begin
            rdata_reg <= mem[addr];
        end
        if (ctrl.we)
        begin
            mem[addr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/point_to_polar_scan_binner.sv -----
// Polar scan binner. Insert requests (tuser 0) carry a point in 1/1024 m;
// a shared shift-add CORDIC unit turns it into range and angle, one step
// per cycle, and one shared multiplier then scales the range and maps the
// angle to one of NUM_BINS sectors over -pi..pi. A range inside
// [min_range, max_range] is written to its bin, and every insert returns
// one result with stored set when the bin was written. Read requests
// (tuser 1) return a bin and refill it with max_range + 1024. An insert
// passes through the CORDIC iterations and then the two multiplier passes
// before its result is ready; a read waits for the registered read of
// the bin memory. One request is in work at a time; a finished result waits
// in the output register while the next request is accepted. After reset,
// a clearing pass writes every bin of the memory before the first request
// is accepted; configuration writes are taken at any time.
module point_to_polar_scan_binner
    import ptpsb_pkg::*;
#(
    parameter int NUM_BINS     = 640,
    parameter int CORDIC_STEPS = 18
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [47:0]   s_tdata,   // point_x[17:0], point_y[35:18], read_bin[45:36]
    input  logic          s_tuser,   // kind[0]
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [31:0]   m_tdata,   // bin_range[17:0], bin_number[27:18], stored[28]
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [RW-1:0] cfg_data
);

    localparam int AW   = $clog2(NUM_BINS);
    localparam int IW   = (AW > BNW) ? AW : BNW;
    localparam int SECW = AW + 1;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_ROT   = 3'd2;
    localparam logic [2:0] ST_MULR  = 3'd3;
    localparam logic [2:0] ST_MULS  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;
    localparam logic [2:0] ST_RDOUT = 3'd6;

    logic [2:0]     state_reg, state_next;
    logic [AW-1:0]  clr_reg, clr_next;
    logic [RW-1:0]  min_range_reg, max_range_reg;
    logic           rd_hit_reg;
    logic [BNW-1:0] rd_bin_reg;
    logic [OW-1:0]  range_reg;
    logic [MPW-1:0] prod_reg;
    logic           m_tvalid_reg, m_tvalid_next;
    logic [31:0]    m_tdata_reg, m_tdata_next;

    logic signed [PW-1:0] point_x, point_y;
    logic [BNW-1:0]       read_bin;
    logic [IW-1:0]        rd_ext;
    logic                 rd_hit;
    logic                 accept;

    cordic_ctrl_t         cordic_ctrl;
    logic signed [XW-1:0] x_out;
    logic signed [ZW-1:0] z_out;
    logic                 cordic_last;

    mem_ctrl_t            mem_ctrl;
    logic [AW-1:0]        mem_addr;
    logic [OW-1:0]        mem_wdata;
    logic [OW-1:0]        mem_rdata;

    logic [MAW-1:0]       mul_a;
    logic [MBW-1:0]       mul_b;
    logic [MPW-1:0]       mul_p;
    logic [MPW:0]         range_rnd;
    logic [MPW-34:0]      range_raw;
    logic [OW-1:0]        range_sat;
    logic signed [ZW:0]   u_s;
    logic [MAW-1:0]       u_clamp;
    logic [MAW-1:0]       x_clamp;
    logic [SECW-1:0]      sector;
    logic                 sec_ok, range_ok, ins_ok;
    logic [OW-1:0]        marker;
    logic                 out_free;

    assign point_x  = $signed(s_tdata[17:0]);
    assign point_y  = $signed(s_tdata[35:18]);
    assign read_bin = s_tdata[45:36];
    assign rd_ext   = IW'(read_bin);
    assign rd_hit   = int'(read_bin) < NUM_BINS;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign marker   = {1'b0, max_range_reg} + EMPTY_EXTRA;

    ptpsb_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (cordic_ctrl),
        .point_x (point_x),
        .point_y (point_y),
        .x_out   (x_out),
        .z_out   (z_out),
        .last    (cordic_last)
    );

    ptpsb_bin_mem #(
        .DEPTH (NUM_BINS),
        .AW    (AW)
    ) u_bin_mem (
        .clk   (clk),
        .ctrl  (mem_ctrl),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // Shared multiplier: range scaling first, then sector mapping
    assign x_clamp = x_out[XW-1] ? '0 : MAW'(x_out[XW-2:0]);
    assign u_s     = $signed({z_out[ZW-1], z_out}) + U_OFFSET;
    assign u_clamp = u_s[ZW] ? '0 : u_s[MAW-1:0];
    assign mul_a   = (state_reg == ST_MULR) ? x_clamp : u_clamp;
    assign mul_b   = (state_reg == ST_MULR) ? GAIN_INV_Q30 : MBW'(NUM_BINS);
    assign mul_p   = MPW'(mul_a) * MPW'(mul_b);

    assign range_rnd = {1'b0, prod_reg} + RANGE_BIAS;
    assign range_raw = range_rnd[MPW:34];
    assign range_sat = (|range_raw[MPW-34:OW]) ? RANGE_SAT : range_raw[OW-1:0];

    assign sector   = prod_reg[32 +: SECW];
    assign sec_ok   = int'(sector) < NUM_BINS;
    assign range_ok = (range_reg >= {1'b0, min_range_reg})
                   && (range_reg <= {1'b0, max_range_reg});
    assign ins_ok   = sec_ok && range_ok;

    always_comb
    begin
        state_next         = state_reg;
        clr_next           = clr_reg;
        cordic_ctrl        = '0;
        mem_ctrl           = '0;
        mem_addr           = clr_reg;
        mem_wdata          = EMPTY_RESET;
        m_tvalid_next      = m_tvalid_reg && !m_tready;
        m_tdata_next       = m_tdata_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_ctrl.we = 1'b1;
                clr_next    = clr_reg + 1'b1;
                if (clr_reg == AW'(NUM_BINS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser)
                    begin
                        // Read the bin and refill it in the same cycle
                        mem_ctrl.re = 1'b1;
                        mem_ctrl.we = rd_hit;
                        mem_addr    = rd_ext[AW-1:0];
                        mem_wdata   = marker;
                        state_next  = ST_RDOUT;
                    end
                    else
                    begin
                        cordic_ctrl.load = 1'b1;
                        state_next       = ST_ROT;
                    end
                end
            end
            ST_ROT:
            begin
                cordic_ctrl.advance = 1'b1;
                if (cordic_last)
                begin
                    state_next = ST_MULR;
                end
            end
            ST_MULR:
            begin
                state_next = ST_MULS;
            end
            ST_MULS:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    mem_ctrl.we   = ins_ok;
                    mem_addr      = sector[AW-1:0];
                    mem_wdata     = range_reg;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, ins_ok,
                                     sec_ok ? BNW'(sector) : {BNW{1'b0}}, range_reg};
                    state_next    = ST_IDLE;
                end
            end
            ST_RDOUT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, 1'b0, rd_bin_reg,
                                     rd_hit_reg ? mem_rdata : marker};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
            min_range_reg <= MIN_RANGE_RST;
            max_range_reg <= MAX_RANGE_RST;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MIN_RANGE: min_range_reg <= cfg_data;
                    REG_MAX_RANGE: max_range_reg <= cfg_data;
                    default:       min_range_reg <= min_range_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        if (accept)
        begin
            rd_hit_reg <= rd_hit;
            rd_bin_reg <= read_bin;
        end
        if (state_reg == ST_MULR || state_reg == ST_MULS)
        begin
            prod_reg <= mul_p;
        end
        if (state_reg == ST_MULS)
        begin
            range_reg <= range_sat;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- tb/sv/point_to_polar_scan_binner_test.sv -----
`timescale 1ns / 100ps

module point_to_polar_scan_binner_test;
    import ptpsb_pkg::*;

    localparam int BINS     = 640;
    localparam int STEPS    = 18;
    localparam int LATENCY  = STEPS + 4;
    localparam int IDLE_MAX = 13;
    localparam int LIMIT    = 400000;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    localparam longint HALF_CIRCLE = 64'sd2147483648;
    localparam longint unsigned GAIN_Q30 = 64'd652032874;
    localparam longint unsigned ROUND_34 = 64'd8589934592;
    localparam longint unsigned SAT_RANGE = 64'd262143;

    typedef struct packed {
        logic           kind;
        logic [PW-1:0]  x;
        logic [PW-1:0]  y;
        logic [BNW-1:0] bin;
    } scan_req_t;

    typedef struct packed {
        logic           stored;
        logic [BNW-1:0] bin_number;
        logic [OW-1:0]  bin_range;
    } scan_res_t;

    logic          clk;
    logic          rst_n;
    logic          s_tvalid;
    logic          s_tready;
    logic [47:0]   s_tdata;   // point_x[17:0], point_y[35:18], read_bin[45:36]
    logic          s_tuser;   // kind[0]
    logic          m_tvalid;
    logic          m_tready;
    logic [31:0]   m_tdata;   // bin_range[17:0], bin_number[27:18], stored[28]
    logic          cfg_we;
    logic          cfg_index;
    logic [RW-1:0] cfg_data;

    // scan model state
    logic [OW-1:0] model_bins [BINS];
    logic [RW-1:0] min_gate;
    logic [RW-1:0] max_gate;
    scan_res_t     results_due [$];

    int  error_count;
    int  cycle_count;
    int  next_gap;
    int  hold_request;
    bit  calm;

    point_to_polar_scan_binner #(
        .NUM_BINS     (BINS),
        .CORDIC_STEPS (STEPS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    function automatic int idle_draw();
        if (calm)
            return 0;
        return $urandom_range(0, IDLE_MAX);
    endfunction

    function automatic logic [PW-1:0] rand_coord();
        logic signed [PW-1:0] v;
        int sh;
        v  = PW'($urandom);
        sh = $urandom_range(0, PW - 1);
        return v >>> sh;
    endfunction

    function automatic logic [OW-1:0] empty_marker();
        return OW'({1'b0, max_gate} + 18'd1024);
    endfunction

    // vectoring CORDIC: range and sector of one point
    function automatic void polar_of(input logic [PW-1:0] xin, input logic [PW-1:0] yin,
                                     output logic [OW-1:0] rng,
                                     output longint unsigned sec);
        longint px;
        longint py;
        longint pz;
        longint dx;
        longint dy;
        longint u;
        longint unsigned prod;
        px = longint'($signed(xin)) * 16;
        py = longint'($signed(yin)) * 16;
        pz = 0;
        if (px < 0)
        begin
            pz = (py >= 0) ? HALF_CIRCLE : -HALF_CIRCLE;
            px = -px;
            py = -py;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            dx = py >>> i;
            dy = px >>> i;
            if (py > 0)
            begin
                px = px + dx;
                py = py - dy;
                pz = pz + longint'(ATAN_TAB[i]);
            end
            else
            begin
                px = px - dx;
                py = py + dy;
                pz = pz - longint'(ATAN_TAB[i]);
            end
        end
        if (px < 0)
            px = 0;
        prod = ($unsigned(px) * GAIN_Q30 + ROUND_34) >> 34;
        if (prod > SAT_RANGE)
            prod = SAT_RANGE;
        rng = prod[OW-1:0];
        u = pz + HALF_CIRCLE;
        if (u < 0)
            u = 0;
        sec = ($unsigned(u) * 64'd640) >> 32;
    endfunction

    // apply one accepted request to the model and queue its result
    task automatic bin_point_request(input scan_req_t r);
        scan_res_t res;
        logic [OW-1:0] rng;
        longint unsigned sec;
        bit ok;
        if (r.kind == KIND_READ)
        begin
            res.stored = 1'b0;
            res.bin_number = r.bin;
            res.bin_range = empty_marker();
            if (r.bin < BINS)
            begin
                res.bin_range = model_bins[r.bin];
                model_bins[r.bin] = empty_marker();
            end
        end
        else
        begin
            polar_of(r.x, r.y, rng, sec);
            ok = ({1'b0, min_gate} <= rng) && (rng <= {1'b0, max_gate});
            if (sec >= BINS)
            begin
                ok = 1'b0;
                sec = 0;
            end
            if (ok)
                model_bins[sec] = rng;
            res.stored = ok;
            res.bin_number = sec[BNW-1:0];
            res.bin_range = rng;
        end
        results_due.push_back(res);
    endtask

    // called at a falling edge; returns at a falling edge
    task automatic send_request(input scan_req_t r);
        if (next_gap > 0)
            repeat (next_gap) @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = r.kind;
        s_tdata  = {2'b00, r.bin, r.y, r.x};
        do
            @(posedge clk);
        while (!s_tready);
        bin_point_request(r);
        @(negedge clk);
        next_gap = idle_draw();
        if (next_gap > 0)
            s_tvalid = 1'b0;
    endtask

    task automatic send_point(input logic [PW-1:0] x, input logic [PW-1:0] y);
        scan_req_t r;
        r.kind = KIND_INSERT;
        r.x = x;
        r.y = y;
        r.bin = BNW'($urandom);
        send_request(r);
    endtask

    task automatic send_read(input logic [BNW-1:0] bin);
        scan_req_t r;
        r.kind = KIND_READ;
        r.x = rand_coord();
        r.y = rand_coord();
        r.bin = bin;
        send_request(r);
    endtask

    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [RW-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        if (idx == REG_MIN_RANGE)
            min_gate = value;
        else
            max_gate = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_window(input logic [RW-1:0] lo, input logic [RW-1:0] hi);
        wait_idle();
        write_reg(REG_MIN_RANGE, lo);
        write_reg(REG_MAX_RANGE, hi);
    endtask

    task automatic check_result(input scan_res_t got);
        scan_res_t want;
        if (results_due.size() == 0)
        begin
            $error("unexpected result: bin_range %0d bin_number %0d stored %0d",
                   got.bin_range, got.bin_number, got.stored);
            error_count++;
            return;
        end
        want = results_due.pop_front();
        if (got.bin_range !== want.bin_range)
        begin
            $error("bin_range: expected %0d, got %0d", want.bin_range, got.bin_range);
            error_count++;
        end
        if (got.bin_number !== want.bin_number)
        begin
            $error("bin_number: expected %0d, got %0d", want.bin_number, got.bin_number);
            error_count++;
        end
        if (got.stored !== want.stored)
        begin
            $error("stored: expected %0d, got %0d", want.stored, got.stored);
            error_count++;
        end
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(negedge clk);
        forever
        begin
            gap = idle_draw();
            if (hold_request > 0)
            begin
                gap = hold_request;
                hold_request = 0;
            end
            if (gap > 0)
            begin
                m_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            check_result(scan_res_t'(m_tdata[28:0]));
            @(negedge clk);
        end
    end

    task automatic test_reset_contents();
        calm = 1'b1;
        send_read(10'd0);
        send_read(10'd639);
        send_read(10'd640);
        send_read(10'd1023);
        send_read(10'd320);
        calm = 1'b0;
        wait_idle();
    endtask

    task automatic test_directed_points();
        send_point(18'sd1000, 18'sd0);
        send_read(10'd320);
        send_point(-18'sd1000, 18'sd0);
        send_point(-18'sd1000, -18'sd1);
        send_point(-18'sd1000, 18'sd1);
        send_point(18'sd0, 18'sd0);
        send_point(18'sd5, 18'sd0);
        send_point(18'sd120000, 18'sd0);
        send_point(18'sd131071, 18'sd131071);
        send_point(-18'sd131072, -18'sd131072);
        send_point(-18'sd131072, 18'sd0);
        send_point(18'sd0, 18'sd131071);
        send_point(18'sd0, -18'sd131072);
        send_point(18'sd131071, -18'sd131072);
        send_point(-18'sd7000, 18'sd7000);
        send_read(10'd320);
        send_read(10'd320);
        wait_idle();
    endtask

    // a read refills with the max_range in force at that moment
    task automatic test_marker_tracking();
        set_window(17'd10, 17'd50000);
        send_point(18'sd20000, 18'sd0);
        send_read(10'd320);
        send_read(10'd320);
        set_window(17'd10, 17'd131071);
        send_read(10'd320);
        send_read(10'd320);
        send_read(10'd700);
        wait_idle();
    endtask

    task automatic test_range_window_extremes();
        set_window(17'd0, 17'd0);
        send_point(18'sd0, 18'sd0);
        send_point(18'sd1, 18'sd0);
        send_point(18'sd0, -18'sd1);
        for (int i = 0; i < 10; i++)
            send_point(rand_coord(), rand_coord());
        set_window(17'd131071, 17'd131071);
        send_point(18'sd131071, 18'sd0);
        send_point(-18'sd131072, 18'sd0);
        for (int i = 0; i < 10; i++)
            send_point(rand_coord(), rand_coord());
        set_window(17'd5000, 17'd1000);
        for (int i = 0; i < 10; i++)
            send_point(rand_coord(), rand_coord());
        send_read(BNW'($urandom_range(0, BINS - 1)));
        wait_idle();
    endtask

    // long stall on the result side while requests keep coming
    task automatic test_backpressure();
        set_window(17'd10, 17'd102400);
        hold_request = 300;
        calm = 1'b1;
        for (int i = 0; i < 16; i++)
        begin
            if (i % 4 == 3)
                send_read(BNW'($urandom_range(0, BINS - 1)));
            else
                send_point(rand_coord(), rand_coord());
        end
        calm = 1'b0;
        wait_idle();
    endtask

    task automatic test_random_scan(input int count, input bit quiet);
        int pick;
        calm = quiet;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
                send_read(BNW'($urandom_range(0, BINS - 1)));
            else if (pick < 30)
                send_read(BNW'($urandom_range(BINS, 1023)));
            else if (pick < 38)
                // near the minus/plus pi seam
                send_point(-PW'($urandom_range(1, 131072)),
                           PW'($signed($urandom_range(0, 4)) - 2));
            else
                send_point(rand_coord(), rand_coord());
        end
        calm = 1'b0;
        wait_idle();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = KIND_INSERT;
        cfg_we       = 1'b0;
        cfg_index    = REG_MIN_RANGE;
        cfg_data     = '0;
        error_count  = 0;
        cycle_count  = 0;
        next_gap     = 0;
        hold_request = 0;
        calm         = 1'b0;
        min_gate     = MIN_RANGE_RST;
        max_gate     = MAX_RANGE_RST;
        for (int i = 0; i < BINS; i++)
            model_bins[i] = EMPTY_RESET;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_contents();
        test_directed_points();
        test_marker_tracking();
        test_range_window_extremes();
        test_backpressure();

        set_window(17'd10, 17'd102400);
        test_random_scan(250, 1'b0);
        set_window(17'd0, 17'd131071);
        test_random_scan(250, 1'b1);
        set_window(RW'($urandom_range(0, 2000)), RW'($urandom_range(20000, 131071)));
        test_random_scan(250, 1'b0);
        set_window(17'd0, 17'd0);
        test_random_scan(150, 1'b0);
        set_window(RW'($urandom_range(0, 131071)), RW'($urandom_range(0, 131071)));
        test_random_scan(150, 1'b0);
        set_window(17'd131071, 17'd131071);
        test_random_scan(150, 1'b0);

        wait_idle();
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
